### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is switched off while reset is asserted.
`define CHK_ON(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that is also evaluated during reset.
`define CHK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/atapio_pkg.sv
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Types, constants and descriptor format shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package atapio_pkg;

    localparam int SECTOR_WORDS = 256;
    localparam int WORD_IDX_W   = $clog2(SECTOR_WORDS);

    localparam int POLL_W = 20;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = POLL_W'(100000);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    localparam logic [28:0] LBA_END = 29'h1000_0000;

    localparam logic [7:0] SR_BSY = 8'h80;
    localparam logic [7:0] SR_RDY = 8'h40;
    localparam logic [7:0] SR_DF  = 8'h20;
    localparam logic [7:0] SR_DRQ = 8'h08;
    localparam logic [7:0] SR_ERR = 8'h01;

    localparam logic [2:0] REG_DATA       = 3'd0;
    localparam logic [2:0] REG_SECT_COUNT = 3'd2;
    localparam logic [2:0] REG_LBA_LO     = 3'd3;
    localparam logic [2:0] REG_LBA_MID    = 3'd4;
    localparam logic [2:0] REG_LBA_HI     = 3'd5;
    localparam logic [2:0] REG_DEVSEL     = 3'd6;
    localparam logic [2:0] REG_CMD_STATUS = 3'd7;

    localparam logic [7:0] DEVSEL_BASE  = 8'he0;
    localparam logic [7:0] DEVSEL_SLAVE = 8'h10;
    localparam logic [7:0] CMD_READ     = 8'h20;
    localparam logic [7:0] CMD_WRITE    = 8'h30;
    localparam logic [7:0] CMD_FLUSH    = 8'he7;

    localparam logic [2:0] REQ_LAST_STEP = 3'd6;

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_STATUS = 2'd2,
        FUNC_DATA   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_REG_WRITE   = 3'd0,
        KIND_DATA_WRITE  = 3'd1,
        KIND_STATUS_READ = 3'd2,
        KIND_DATA_READ   = 3'd3,
        KIND_HOST_DATA   = 3'd4,
        KIND_NEED_SECTOR = 3'd5,
        KIND_DONE        = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        CODE_OK          = 2'd0,
        CODE_DEV_ERROR   = 2'd1,
        CODE_TIMEOUT     = 2'd2,
        CODE_BAD_REQUEST = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_DRQ   = 2'd1,
        PH_XFER       = 2'd2,
        PH_WAIT_READY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_ONE = 2'd0,
        OP_TWO = 2'd1,
        OP_REQ = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        kind_t       a_kind;
        logic [2:0]  a_reg;
        logic [15:0] a_value;
        code_t       a_code;
        kind_t       b_kind;
        logic [2:0]  b_reg;
        code_t       b_code;
        logic [27:0] lba;
        logic [7:0]  count;
        logic        slave;
        logic        wr;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  reg_index;
        logic [15:0] value;
        code_t       code;
    } beat_t;

endpackage

`default_nettype wire

### hdl/atapio_front.sv
// ----------------------------------------------------------------------------
// ATA PIO sequencer front end
// Accepts request, status and data beats, runs the command state machine and
// queues a descriptor of the result beats that each accepted item causes.
// ----------------------------------------------------------------------------
`default_nettype none

module atapio_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [atapio_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic [atapio_pkg::IN_USER_W-1:0]     s_tuser,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [atapio_pkg::POLL_W-1:0]        cfg_wr_data,
    input  wire atapio_pkg::fifo_stat_t               q_stat,
    output logic                                      q_push,
    output atapio_pkg::desc_t                         q_desc
);

    function automatic atapio_pkg::desc_t mk(
        input atapio_pkg::op_t   op,
        input atapio_pkg::kind_t ak,
        input logic [2:0]        ar,
        input logic [15:0]       av,
        input atapio_pkg::code_t ac,
        input atapio_pkg::kind_t bk,
        input logic [2:0]        br,
        input atapio_pkg::code_t bc
    );
        atapio_pkg::desc_t d;
        d         = '0;
        d.op      = op;
        d.a_kind  = ak;
        d.a_reg   = ar;
        d.a_value = av;
        d.a_code  = ac;
        d.b_kind  = bk;
        d.b_reg   = br;
        d.b_code  = bc;
        return d;
    endfunction

    atapio_pkg::phase_t                    phase_reg, phase_next;
    logic                                  is_write_reg, is_write_next;
    logic [7:0]                            sectors_left_reg, sectors_left_next;
    logic [atapio_pkg::WORD_IDX_W-1:0]     word_index_reg, word_index_next;
    logic [atapio_pkg::POLL_W-1:0]         poll_count_reg, poll_count_next;
    logic                                  flush_reg, flush_next;
    logic [atapio_pkg::POLL_W-1:0]         poll_limit_reg;

    atapio_pkg::func_t  func;
    logic [27:0]        lba;
    logic [7:0]         count;
    logic               slave;
    logic [7:0]         st;
    logic [15:0]        word;
    logic               accept;
    logic [28:0]        lba_end;
    logic [atapio_pkg::POLL_W-1:0] poll_inc;
    logic [7:0]         sectors_dec;
    logic               st_fault;
    atapio_pkg::desc_t  status_desc;
    atapio_pkg::kind_t  word_kind;

    assign func  = atapio_pkg::func_t'(s_tuser);
    assign lba   = s_tdata[27:0];
    assign count = s_tdata[35:28];
    assign slave = s_tdata[36];
    assign st    = s_tdata[44:37];
    assign word  = s_tdata[60:45];

    assign s_tready    = !q_stat.full;
    assign accept      = s_tvalid && s_tready;
    assign lba_end     = {1'b0, lba} + {21'd0, count};
    assign poll_inc    = poll_count_reg + 1'b1;
    assign sectors_dec = sectors_left_reg - 1'b1;
    assign st_fault    = |(st & (atapio_pkg::SR_ERR | atapio_pkg::SR_DF));
    assign word_kind   = is_write_reg ? atapio_pkg::KIND_DATA_WRITE
                                      : atapio_pkg::KIND_HOST_DATA;
    assign status_desc = mk(atapio_pkg::OP_ONE, atapio_pkg::KIND_STATUS_READ,
                            atapio_pkg::REG_CMD_STATUS, 16'd0, atapio_pkg::CODE_OK,
                            atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                            atapio_pkg::CODE_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= atapio_pkg::PH_IDLE;
            is_write_reg     <= 1'b0;
            sectors_left_reg <= '0;
            word_index_reg   <= '0;
            poll_count_reg   <= '0;
            flush_reg        <= 1'b0;
            poll_limit_reg   <= atapio_pkg::POLL_LIMIT_RESET;
        end else begin
            phase_reg        <= phase_next;
            is_write_reg     <= is_write_next;
            sectors_left_reg <= sectors_left_next;
            word_index_reg   <= word_index_next;
            poll_count_reg   <= poll_count_next;
            flush_reg        <= flush_next;
            if (cfg_wr_en) begin
                poll_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        is_write_next     = is_write_reg;
        sectors_left_next = sectors_left_reg;
        word_index_next   = word_index_reg;
        poll_count_next   = poll_count_reg;
        flush_next        = flush_reg;
        q_push            = 1'b0;
        q_desc            = status_desc;

        if (accept) begin
            case (phase_reg)
                atapio_pkg::PH_IDLE: begin
                    if (func == atapio_pkg::FUNC_READ || func == atapio_pkg::FUNC_WRITE) begin
                        q_push = 1'b1;
                        if (count == 8'd0 || lba_end > atapio_pkg::LBA_END) begin
                            q_desc = mk(atapio_pkg::OP_ONE, atapio_pkg::KIND_DONE,
                                        atapio_pkg::REG_DATA, 16'd0,
                                        atapio_pkg::CODE_BAD_REQUEST,
                                        atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                        atapio_pkg::CODE_OK);
                        end else begin
                            q_desc.op    = atapio_pkg::OP_REQ;
                            q_desc.lba   = lba;
                            q_desc.count = count;
                            q_desc.slave = slave;
                            q_desc.wr    = (func == atapio_pkg::FUNC_WRITE);
                            is_write_next     = (func == atapio_pkg::FUNC_WRITE);
                            sectors_left_next = count;
                            word_index_next   = '0;
                            flush_next        = 1'b0;
                            poll_count_next   = '0;
                            phase_next        = atapio_pkg::PH_WAIT_DRQ;
                        end
                    end
                end
                atapio_pkg::PH_WAIT_DRQ, atapio_pkg::PH_WAIT_READY: begin
                    if (func == atapio_pkg::FUNC_STATUS) begin
                        q_push = 1'b1;
                        if (st_fault) begin
                            q_desc = mk(atapio_pkg::OP_ONE, atapio_pkg::KIND_DONE,
                                        atapio_pkg::REG_DATA, 16'd0,
                                        atapio_pkg::CODE_DEV_ERROR,
                                        atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                        atapio_pkg::CODE_OK);
                            phase_next = atapio_pkg::PH_IDLE;
                        end else if (phase_reg == atapio_pkg::PH_WAIT_DRQ
                                     && !(|(st & atapio_pkg::SR_BSY))
                                     && (|(st & atapio_pkg::SR_DRQ))) begin
                            q_desc = mk(atapio_pkg::OP_ONE,
                                        is_write_reg ? atapio_pkg::KIND_NEED_SECTOR
                                                     : atapio_pkg::KIND_DATA_READ,
                                        atapio_pkg::REG_DATA, 16'd0, atapio_pkg::CODE_OK,
                                        atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                        atapio_pkg::CODE_OK);
                            phase_next      = atapio_pkg::PH_XFER;
                            word_index_next = '0;
                        end else if (phase_reg == atapio_pkg::PH_WAIT_READY
                                     && !(|(st & atapio_pkg::SR_BSY))
                                     && (|(st & atapio_pkg::SR_RDY))) begin
                            if (!flush_reg) begin
                                q_desc = mk(atapio_pkg::OP_TWO, atapio_pkg::KIND_REG_WRITE,
                                            atapio_pkg::REG_CMD_STATUS,
                                            {8'd0, atapio_pkg::CMD_FLUSH},
                                            atapio_pkg::CODE_OK,
                                            atapio_pkg::KIND_STATUS_READ,
                                            atapio_pkg::REG_CMD_STATUS,
                                            atapio_pkg::CODE_OK);
                                flush_next      = 1'b1;
                                poll_count_next = '0;
                            end else begin
                                q_desc = mk(atapio_pkg::OP_ONE, atapio_pkg::KIND_DONE,
                                            atapio_pkg::REG_DATA, 16'd0,
                                            atapio_pkg::CODE_OK,
                                            atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                            atapio_pkg::CODE_OK);
                                phase_next = atapio_pkg::PH_IDLE;
                            end
                        end else begin
                            poll_count_next = poll_inc;
                            if (poll_inc >= poll_limit_reg) begin
                                q_desc = mk(atapio_pkg::OP_ONE, atapio_pkg::KIND_DONE,
                                            atapio_pkg::REG_DATA, 16'd0,
                                            atapio_pkg::CODE_TIMEOUT,
                                            atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                            atapio_pkg::CODE_OK);
                                phase_next = atapio_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                atapio_pkg::PH_XFER: begin
                    if (func == atapio_pkg::FUNC_DATA) begin
                        q_push = 1'b1;
                        if (word_index_reg
                            != atapio_pkg::WORD_IDX_W'(atapio_pkg::SECTOR_WORDS - 1)) begin
                            word_index_next = word_index_reg + 1'b1;
                            q_desc = mk(is_write_reg ? atapio_pkg::OP_ONE : atapio_pkg::OP_TWO,
                                        word_kind, atapio_pkg::REG_DATA, word,
                                        atapio_pkg::CODE_OK,
                                        atapio_pkg::KIND_DATA_READ, atapio_pkg::REG_DATA,
                                        atapio_pkg::CODE_OK);
                        end else begin
                            word_index_next   = '0;
                            sectors_left_next = sectors_dec;
                            if (sectors_dec != 8'd0 || is_write_reg) begin
                                q_desc = mk(atapio_pkg::OP_TWO, word_kind,
                                            atapio_pkg::REG_DATA, word, atapio_pkg::CODE_OK,
                                            atapio_pkg::KIND_STATUS_READ,
                                            atapio_pkg::REG_CMD_STATUS,
                                            atapio_pkg::CODE_OK);
                                poll_count_next = '0;
                                phase_next = (sectors_dec != 8'd0)
                                             ? atapio_pkg::PH_WAIT_DRQ
                                             : atapio_pkg::PH_WAIT_READY;
                            end else begin
                                q_desc = mk(atapio_pkg::OP_TWO, word_kind,
                                            atapio_pkg::REG_DATA, word, atapio_pkg::CODE_OK,
                                            atapio_pkg::KIND_DONE, atapio_pkg::REG_DATA,
                                            atapio_pkg::CODE_OK);
                                phase_next = atapio_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = atapio_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/atapio_fifo.sv
// ----------------------------------------------------------------------------
// ATA PIO sequencer descriptor queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module atapio_fifo (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire atapio_pkg::desc_t       push_data,
    input  wire logic                    pop,
    output atapio_pkg::desc_t            pop_data,
    output atapio_pkg::fifo_stat_t       stat
);

    atapio_pkg::desc_t mem [atapio_pkg::FIFO_DEPTH];

    logic [atapio_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [atapio_pkg::FIFO_PTR_W:0]   fill_reg, fill_next;
    logic                              do_push, do_pop;

    assign stat.full  = (fill_reg == (atapio_pkg::FIFO_PTR_W + 1)'(atapio_pkg::FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/atapio_back.sv
// ----------------------------------------------------------------------------
// ATA PIO sequencer back end
// Expands queued descriptors into result beats, one per cycle while the sink is
// ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atapio_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire atapio_pkg::desc_t                    q_desc,
    input  wire atapio_pkg::fifo_stat_t               q_stat,
    output logic                                      q_pop,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [atapio_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [atapio_pkg::OUT_USER_W-1:0]         m_tuser,
    output logic                                      m_tlast
);

    logic [2:0]         step_reg;
    logic               m_tvalid_reg;
    logic               m_tlast_reg;
    atapio_pkg::beat_t  beat_reg;
    atapio_pkg::beat_t  beat;
    logic               is_last;
    logic               load;
    logic [7:0]         devsel;

    assign devsel = atapio_pkg::DEVSEL_BASE
                  | (q_desc.slave ? atapio_pkg::DEVSEL_SLAVE : 8'd0)
                  | {4'd0, q_desc.lba[27:24]};

    always_comb begin
        beat.kind      = atapio_pkg::KIND_REG_WRITE;
        beat.reg_index = atapio_pkg::REG_DATA;
        beat.value     = 16'd0;
        beat.code      = atapio_pkg::CODE_OK;
        is_last        = 1'b1;
        case (q_desc.op)
            atapio_pkg::OP_REQ: begin
                is_last = (step_reg == atapio_pkg::REQ_LAST_STEP);
                case (step_reg)
                    3'd0: begin
                        beat.reg_index = atapio_pkg::REG_DEVSEL;
                        beat.value     = {8'd0, devsel};
                    end
                    3'd1: begin
                        beat.reg_index = atapio_pkg::REG_SECT_COUNT;
                        beat.value     = {8'd0, q_desc.count};
                    end
                    3'd2: begin
                        beat.reg_index = atapio_pkg::REG_LBA_LO;
                        beat.value     = {8'd0, q_desc.lba[7:0]};
                    end
                    3'd3: begin
                        beat.reg_index = atapio_pkg::REG_LBA_MID;
                        beat.value     = {8'd0, q_desc.lba[15:8]};
                    end
                    3'd4: begin
                        beat.reg_index = atapio_pkg::REG_LBA_HI;
                        beat.value     = {8'd0, q_desc.lba[23:16]};
                    end
                    3'd5: begin
                        beat.reg_index = atapio_pkg::REG_CMD_STATUS;
                        beat.value     = {8'd0, q_desc.wr ? atapio_pkg::CMD_WRITE
                                                          : atapio_pkg::CMD_READ};
                    end
                    default: begin
                        beat.kind      = atapio_pkg::KIND_STATUS_READ;
                        beat.reg_index = atapio_pkg::REG_CMD_STATUS;
                    end
                endcase
            end
            atapio_pkg::OP_TWO: begin
                is_last = (step_reg != 3'd0);
                if (step_reg == 3'd0) begin
                    beat.kind      = q_desc.a_kind;
                    beat.reg_index = q_desc.a_reg;
                    beat.value     = q_desc.a_value;
                    beat.code      = q_desc.a_code;
                end else begin
                    beat.kind      = q_desc.b_kind;
                    beat.reg_index = q_desc.b_reg;
                    beat.code      = q_desc.b_code;
                end
            end
            default: begin
                beat.kind      = q_desc.a_kind;
                beat.reg_index = q_desc.a_reg;
                beat.value     = q_desc.a_value;
                beat.code      = q_desc.a_code;
            end
        endcase
    end

    assign load  = !q_stat.empty && (!m_tvalid_reg || m_tready);
    assign q_pop = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                step_reg     <= is_last ? 3'd0 : step_reg + 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg    <= beat;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = beat_reg.kind;
    assign m_tdata  = {3'd0, beat_reg.code, beat_reg.value, beat_reg.reg_index};

endmodule

`default_nettype wire

### hdl/ata_pio_command_sequencer.sv
// ----------------------------------------------------------------------------
// ATA PIO LBA28 command sequencer
// Host-side sequencer that turns read and write requests into task-file
// accesses, status polls and sector data transfers.
// ----------------------------------------------------------------------------
// The front end takes one input beat per cycle while its four-entry descriptor
// queue has room, and the back end sends one result beat per cycle while the
// sink is ready. Each item gives result beats: none for an ignored beat, one
// for a rejected request, one or two for a status byte or data word and seven
// for an accepted command, so the sustained rate is set by the output port and
// the queue only absorbs bursts. When the queue is empty, the first result beat
// of an item passes through the queue entry and then the registered output
// stage before it is valid.
`default_nettype none
`include "assert_macros.svh"

module ata_pio_command_sequencer (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: lba[27:0], count[35:28], drive_slave[36], status_byte[44:37],
    // data_word[60:45], zero[63:61]
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [atapio_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: func[1:0]
    input  wire logic [atapio_pkg::IN_USER_W-1:0]     s_tuser,
    // m_tdata: reg_index[2:0], value[18:3], code[20:19], zero[23:21]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [atapio_pkg::OUT_DATA_W-1:0]         m_tdata,
    // m_tuser: kind[2:0]
    output logic [atapio_pkg::OUT_USER_W-1:0]         m_tuser,
    output logic                                      m_tlast,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [atapio_pkg::POLL_W-1:0]        cfg_wr_data
);

    atapio_pkg::fifo_stat_t q_stat;
    atapio_pkg::desc_t      push_desc;
    atapio_pkg::desc_t      head_desc;
    logic                   q_push;
    logic                   q_pop;

    atapio_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_desc      (push_desc)
    );

    atapio_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_desc),
        .pop       (q_pop),
        .pop_data  (head_desc),
        .stat      (q_stat)
    );

    atapio_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_desc   (head_desc),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `CHK_ALWAYS(a_reset_no_output, aclk, !aresetn |=> !m_tvalid, "Output valid after reset")
    `CHK_ON(a_done_is_last, aclk, aresetn, (m_tvalid && m_tuser == atapio_pkg::KIND_DONE) |-> m_tlast, "Done beat not marked last")
    `CHK_ON(a_status_reg, aclk, aresetn, (m_tvalid && m_tuser == atapio_pkg::KIND_STATUS_READ) |-> (m_tdata[2:0] == atapio_pkg::REG_CMD_STATUS), "Status read not at status register")

endmodule

`default_nettype wire

### verif/ata_pio_command_sequencer_tb.sv
// ----------------------------------------------------------------------------
// ATA PIO command sequencer testbench
// Feeds read and write requests, device status bytes and data words to the
// sequencer and checks every result beat against a cycle-free model of the
// task-file, polling and sector-transfer behaviour. A short directed section
// covers rejected requests, device errors, poll timeouts and ignored beats;
// random command sequences then run under several poll limits, with bursty
// input traffic and a stalling result sink.
// ----------------------------------------------------------------------------
module ata_pio_command_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atapio_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 12;

    typedef struct packed {
        func_t       func;
        logic [27:0] lba;
        logic [7:0]  count;
        logic        slave;
        logic [7:0]  status;
        logic [15:0] word;
    } bus_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  reg_index;
        logic [15:0] value;
        code_t       code;
        logic        last;
    } seq_beat_t;

    typedef enum int {
        END_OK,
        END_ERROR,
        END_TIMEOUT
    } wait_end_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_STARVED,
        RX_PATTERN
    } rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [POLL_W-1:0]     cfg_wr_data = '0;

    bus_item_t stim_q[$];
    seq_beat_t awaited_beats[$];
    int        items_sent = 0;
    int        error_count = 0;

    // Sequencer model state.
    phase_t            seq_phase = PH_IDLE;
    logic              seq_write = 1'b0;
    logic [7:0]        seq_sectors = '0;
    logic [8:0]        seq_word = '0;
    logic [POLL_W-1:0] seq_polls = '0;
    logic              seq_flushed = 1'b0;
    logic [POLL_W-1:0] seq_limit = POLL_LIMIT_RESET;
    int                step_beats;

    ata_pio_command_sequencer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic void add_beat(kind_t k, logic [2:0] r, logic [15:0] v, code_t c);
        seq_beat_t b;
        b.kind = k;
        b.reg_index = r;
        b.value = v;
        b.code = c;
        b.last = 1'b0;
        awaited_beats.push_back(b);
        step_beats++;
    endfunction

    function automatic void end_command(code_t c);
        add_beat(KIND_DONE, REG_DATA, 16'h0000, c);
        seq_phase = PH_IDLE;
    endfunction

    function automatic void begin_wait(phase_t ph);
        seq_phase = ph;
        seq_polls = '0;
        add_beat(KIND_STATUS_READ, REG_CMD_STATUS, 16'h0000, CODE_OK);
    endfunction

    function automatic void retry_poll();
        seq_polls = seq_polls + 1'b1;
        if (seq_polls >= seq_limit) begin
            end_command(CODE_TIMEOUT);
        end else begin
            add_beat(KIND_STATUS_READ, REG_CMD_STATUS, 16'h0000, CODE_OK);
        end
    endfunction

    function automatic void advance_sequencer(func_t f, logic [27:0] lba, logic [7:0] cnt,
                                              logic slv, logic [7:0] st, logic [15:0] w);
        step_beats = 0;
        case (seq_phase)
            PH_IDLE: begin
                if (f == FUNC_READ || f == FUNC_WRITE) begin
                    if (cnt == 0 || 32'(lba) + 32'(cnt) - 1 >= 32'(LBA_END)) begin
                        end_command(CODE_BAD_REQUEST);
                    end else begin
                        seq_write = (f == FUNC_WRITE);
                        seq_sectors = cnt;
                        seq_word = '0;
                        seq_flushed = 1'b0;
                        add_beat(KIND_REG_WRITE, REG_DEVSEL,
                                 16'(DEVSEL_BASE | (slv ? DEVSEL_SLAVE : 8'h00)
                                     | {4'h0, lba[27:24]}), CODE_OK);
                        add_beat(KIND_REG_WRITE, REG_SECT_COUNT, 16'(cnt), CODE_OK);
                        add_beat(KIND_REG_WRITE, REG_LBA_LO, 16'(lba[7:0]), CODE_OK);
                        add_beat(KIND_REG_WRITE, REG_LBA_MID, 16'(lba[15:8]), CODE_OK);
                        add_beat(KIND_REG_WRITE, REG_LBA_HI, 16'(lba[23:16]), CODE_OK);
                        add_beat(KIND_REG_WRITE, REG_CMD_STATUS,
                                 16'(seq_write ? CMD_WRITE : CMD_READ), CODE_OK);
                        begin_wait(PH_WAIT_DRQ);
                    end
                end
            end
            PH_WAIT_DRQ: begin
                if (f == FUNC_STATUS) begin
                    if ((st & (SR_ERR | SR_DF)) != 0) begin
                        end_command(CODE_DEV_ERROR);
                    end else if ((st & SR_BSY) == 0 && (st & SR_DRQ) != 0) begin
                        seq_phase = PH_XFER;
                        seq_word = '0;
                        add_beat(seq_write ? KIND_NEED_SECTOR : KIND_DATA_READ, REG_DATA,
                                 16'h0000, CODE_OK);
                    end else begin
                        retry_poll();
                    end
                end
            end
            PH_XFER: begin
                if (f == FUNC_DATA) begin
                    add_beat(seq_write ? KIND_DATA_WRITE : KIND_HOST_DATA, REG_DATA, w, CODE_OK);
                    if (int'(seq_word) + 1 < SECTOR_WORDS) begin
                        seq_word = seq_word + 1'b1;
                        if (!seq_write) begin
                            add_beat(KIND_DATA_READ, REG_DATA, 16'h0000, CODE_OK);
                        end
                    end else begin
                        seq_word = '0;
                        seq_sectors = seq_sectors - 1'b1;
                        if (seq_sectors != 0) begin
                            begin_wait(PH_WAIT_DRQ);
                        end else if (seq_write) begin
                            begin_wait(PH_WAIT_READY);
                        end else begin
                            end_command(CODE_OK);
                        end
                    end
                end
            end
            default: begin
                if (f == FUNC_STATUS) begin
                    if ((st & (SR_ERR | SR_DF)) != 0) begin
                        end_command(CODE_DEV_ERROR);
                    end else if ((st & SR_BSY) == 0 && (st & SR_RDY) != 0) begin
                        if (!seq_flushed) begin
                            seq_flushed = 1'b1;
                            add_beat(KIND_REG_WRITE, REG_CMD_STATUS, 16'(CMD_FLUSH), CODE_OK);
                            begin_wait(PH_WAIT_READY);
                        end else begin
                            end_command(CODE_OK);
                        end
                    end else begin
                        retry_poll();
                    end
                end
            end
        endcase
        if (step_beats > 0) begin
            awaited_beats[awaited_beats.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input driver and result sink
    // ------------------------------------------------------------------------
    bus_item_t drv_item;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || stim_q.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_tvalid <= 1'b0;
            end else begin
                drv_item = stim_q.pop_front();
                s_tdata <= {3'b000, drv_item.word, drv_item.status, drv_item.slave,
                            drv_item.count, drv_item.lba};
                s_tuser <= drv_item.func;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end else begin
                rx_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom);
                RX_STARVED: m_tready <= ($urandom_range(0, 5) == 0);
                default:    m_tready <= (rx_tick % 7) < 3;
            endcase
        end
    end

    seq_beat_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            seq_phase = PH_IDLE;
            seq_write = 1'b0;
            seq_sectors = '0;
            seq_word = '0;
            seq_polls = '0;
            seq_flushed = 1'b0;
            seq_limit = POLL_LIMIT_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_sequencer(func_t'(s_tuser), s_tdata[27:0], s_tdata[35:28], s_tdata[36],
                                  s_tdata[44:37], s_tdata[60:45]);
            end
            if (m_tvalid && m_tready) begin
                if (awaited_beats.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d", m_tuser);
                    error_count++;
                end else begin
                    want = awaited_beats.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("reg_index", want.reg_index, m_tdata[2:0]);
                    check_field("value", want.value, m_tdata[18:3]);
                    check_field("code", want.code, m_tdata[20:19]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic bus_item_t random_item(func_t f);
        bus_item_t it;
        it.func = f;
        it.lba = 28'($urandom);
        it.count = 8'($urandom);
        it.slave = 1'($urandom);
        it.status = 8'($urandom);
        it.word = 16'($urandom);
        return it;
    endfunction

    function automatic void push_request(func_t f, logic [27:0] lba, logic [7:0] cnt, logic slv);
        bus_item_t it;
        it = random_item(f);
        it.lba = lba;
        it.count = cnt;
        it.slave = slv;
        stim_q.push_back(it);
        items_sent++;
    endfunction

    function automatic void push_status(logic [7:0] st);
        bus_item_t it;
        it = random_item(FUNC_STATUS);
        it.status = st;
        stim_q.push_back(it);
        items_sent++;
    endfunction

    function automatic void push_word(logic [15:0] w);
        bus_item_t it;
        it = random_item(FUNC_DATA);
        it.word = w;
        stim_q.push_back(it);
        items_sent++;
    endfunction

    // Only called where the sequencer is known to drop this kind of beat.
    function automatic void push_noise(func_t f);
        stim_q.push_back(random_item(f));
    endfunction

    function automatic logic [7:0] status_with(logic [7:0] set_bits, logic [7:0] clear_bits);
        return (8'($urandom) & ~clear_bits) | set_bits;
    endfunction

    function automatic int eff_limit();
        return (seq_limit == 0) ? 1 : int'(seq_limit);
    endfunction

    function automatic wait_end_t pick_abort();
        if (eff_limit() <= 8 && $urandom_range(0, 1) == 1) begin
            return END_TIMEOUT;
        end
        return END_ERROR;
    endfunction

    function automatic void push_wait(logic for_ready, wait_end_t fate);
        int         fails;
        int         top;
        logic [7:0] good_bit;
        good_bit = for_ready ? SR_RDY : SR_DRQ;
        top = (eff_limit() - 1 < 3) ? eff_limit() - 1 : 3;
        fails = (fate == END_TIMEOUT) ? eff_limit() : $urandom_range(0, top);
        repeat (fails) begin
            if ($urandom_range(0, 3) == 0) begin
                push_noise(func_t'($urandom_range(0, 1)) == FUNC_READ ? FUNC_DATA
                                                                         : FUNC_WRITE);
            end
            push_status($urandom_range(0, 1) ? status_with(SR_BSY, SR_ERR | SR_DF)
                                             : status_with(8'h00, good_bit | SR_ERR | SR_DF));
        end
        if (fate == END_OK) begin
            push_status(status_with(good_bit, SR_BSY | SR_ERR | SR_DF));
        end else if (fate == END_ERROR) begin
            push_status($urandom_range(0, 1) ? status_with(SR_ERR, 8'h00)
                                             : status_with(SR_DF, 8'h00));
        end
    endfunction

    // Waits are numbered from zero: one ahead of each sector, then for a write
    // the wait for ready and the wait after the cache flush.
    function automatic void push_command(func_t f, int sectors, int abort_at);
        int w;
        push_request(f, 28'($urandom_range(0, 32'h1000_0000 - sectors)), 8'(sectors),
                     1'($urandom));
        for (w = 0; w < sectors; w++) begin
            if (w == abort_at) begin
                push_wait(1'b0, pick_abort());
                return;
            end
            push_wait(1'b0, END_OK);
            repeat (SECTOR_WORDS) begin
                if ($urandom_range(0, 63) == 0) begin
                    push_noise(func_t'($urandom_range(0, 2)));
                end
                push_word(16'($urandom));
            end
        end
        if (f == FUNC_WRITE) begin
            for (w = sectors; w < sectors + 2; w++) begin
                if (w == abort_at) begin
                    push_wait(1'b1, pick_abort());
                    return;
                end
                push_wait(1'b1, END_OK);
            end
        end
    endfunction

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (stim_q.size() != 0 || s_tvalid || awaited_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_poll_limit(logic [POLL_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seq_limit = v;
    endtask

    logic [POLL_W-1:0] phase_limits [5];
    int                goal;
    int                seq_no = 0;
    int                pick;
    int                cnt;
    func_t             req_func;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        write_poll_limit(POLL_W'(2));
        push_request(FUNC_READ, 28'h000_0000, 8'd0, 1'b0);
        push_request(FUNC_WRITE, 28'hfff_ffff, 8'd2, 1'b1);
        push_status(8'hff);
        push_word(16'hffff);
        push_request(FUNC_WRITE, 28'hfff_ffff, 8'd1, 1'b1);
        push_status(8'hff);
        push_request(FUNC_READ, 28'h000_0000, 8'd255, 1'b0);
        push_status(SR_BSY | SR_DRQ);
        push_status(8'h00);
        push_request(FUNC_READ, 28'hfff_ff01, 8'd255, 1'b1);
        push_noise(FUNC_DATA);
        push_noise(FUNC_WRITE);
        push_status(SR_DF | SR_RDY);
        push_request(FUNC_WRITE, 28'haaa_aaaa, 8'h80, 1'b0);
        push_status(SR_ERR);
        push_request(FUNC_READ, 28'h555_5555, 8'h7f, 1'b1);
        push_status(SR_RDY | 8'h10);
        push_status(SR_ERR | SR_DRQ);

        phase_limits = '{POLL_W'(1), {POLL_W{1'b1}}, POLL_W'(0),
                         POLL_W'($urandom_range(2, 6)), POLL_W'($urandom_range(3, 8))};
        foreach (phase_limits[p]) begin
            wait_idle();
            write_poll_limit(phase_limits[p]);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                req_func = func_t'($urandom_range(0, 1));
                if (seq_no == 0) begin
                    push_command(FUNC_READ, 1, -1);
                end else if (seq_no == 1) begin
                    push_command(FUNC_WRITE, 1, -1);
                end else begin
                    pick = $urandom_range(0, 29);
                    if (pick < 5) begin
                        if ($urandom_range(0, 1) == 0) begin
                            push_request(req_func, 28'($urandom), 8'd0, 1'($urandom));
                        end else begin
                            cnt = $urandom_range(2, 255);
                            push_request(req_func, 28'hfff_ffff - 28'($urandom_range(0, cnt - 2)),
                                         8'(cnt), 1'($urandom));
                        end
                    end else if (pick < 28) begin
                        push_command(req_func, $urandom_range(1, 255), 0);
                    end else begin
                        repeat ($urandom_range(1, 3)) push_noise(func_t'($urandom_range(2, 3)));
                    end
                end
                seq_no++;
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
